@@ sv/lru_kv_pkg.sv @@
// Shared types and constants of the LRU key-value cache.
package lru_kv_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W       = 5;
	localparam int WORD_W      = 32;
	localparam int CMP_W       = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]         rank_t;
	typedef logic [CNT_W-1:0]         count_t;
	typedef logic [CAP_W-1:0]         cap_t;

	localparam word_t READ_MISS = -32'sd1;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	// recency state: valid bits, ranks and fill count
	typedef struct packed {
		logic [MAX_ENTRIES-1:0]  valid;
		rank_t [MAX_ENTRIES-1:0] rank;
		count_t                  count;
	} lru_ctrl_t;

	// entry write: one-hot select, key written only on insert
	typedef struct packed {
		logic [MAX_ENTRIES-1:0] sel;
		logic                   key_en;
		word_t                  key;
		word_t                  data;
	} entry_wr_t;

	typedef struct packed {
		logic   found;
		word_t  read_value;
		word_t  head_value;
		word_t  tail_value;
		logic   store_empty;
		count_t occupancy;
	} lru_result_t;

endpackage

@@ sv/lru_kv_store.sv @@
// Entry storage: keys, data, valid bits, recency ranks and fill count.
module lru_kv_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  commit,
	input  lru_kv_pkg::lru_ctrl_t ctrl_next,
	input  lru_kv_pkg::entry_wr_t wr,
	output lru_kv_pkg::lru_ctrl_t ctrl,
	output lru_kv_pkg::word_t     keys [lru_kv_pkg::MAX_ENTRIES],
	output lru_kv_pkg::word_t     datas [lru_kv_pkg::MAX_ENTRIES]
);

	lru_kv_pkg::lru_ctrl_t ctrl_q;
	lru_kv_pkg::word_t     key_q [lru_kv_pkg::MAX_ENTRIES];
	lru_kv_pkg::word_t     data_q [lru_kv_pkg::MAX_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (commit) begin
			ctrl_q <= ctrl_next;
		end
	end

	// payload, no reset: only read through a valid bit
	always_ff @(posedge clk) begin
		for (int i = 0; i < lru_kv_pkg::MAX_ENTRIES; i++) begin
			if (commit && wr.sel[i]) begin
				data_q[i] <= wr.data;
				if (wr.key_en) begin
					key_q[i] <= wr.key;
				end
			end
		end
	end

	assign ctrl  = ctrl_q;
	assign keys  = key_q;
	assign datas = data_q;

endmodule

@@ sv/lru_kv_update.sv @@
// Single-pass lookup, promotion, eviction, insertion and result forming.
module lru_kv_update (
	input  lru_kv_pkg::cmd_t        cmd,
	input  lru_kv_pkg::word_t       key,
	input  lru_kv_pkg::word_t       val,
	input  lru_kv_pkg::cap_t        capacity,
	input  lru_kv_pkg::lru_ctrl_t   ctrl,
	input  lru_kv_pkg::word_t       keys [lru_kv_pkg::MAX_ENTRIES],
	input  lru_kv_pkg::word_t       datas [lru_kv_pkg::MAX_ENTRIES],
	output lru_kv_pkg::lru_ctrl_t   ctrl_next,
	output lru_kv_pkg::entry_wr_t   wr,
	output lru_kv_pkg::lru_result_t result
);

	localparam int N = lru_kv_pkg::MAX_ENTRIES;
	localparam int CW = lru_kv_pkg::CMP_W;

	logic [N-1:0]              match;
	logic                      hit;
	lru_kv_pkg::rank_t         hit_rank;
	lru_kv_pkg::word_t         hit_data;
	logic [CW-1:0]             eff_cap;
	logic                      evict;
	lru_kv_pkg::rank_t         ev_rank;
	logic [N-1:0]              valid_e;
	lru_kv_pkg::count_t        count_e;
	logic [N-1:0]              free_oh;
	logic                      free_any;
	lru_kv_pkg::rank_t         tail_rank;
	lru_kv_pkg::word_t         dn;

	always_comb begin
		match    = '0;
		hit_rank = '0;
		hit_data = '0;
		for (int i = 0; i < N; i++) begin
			match[i] = ctrl.valid[i] && (keys[i] == key);
			if (match[i]) begin
				hit_rank = hit_rank | ctrl.rank[i];
				hit_data = hit_data | datas[i];
			end
		end
		hit = |match;

		// capacity clipped to 1..MAX_ENTRIES
		if (capacity == '0) begin
			eff_cap = CW'(1);
		end else if (CW'(capacity) > CW'(N)) begin
			eff_cap = CW'(N);
		end else begin
			eff_cap = CW'(capacity);
		end

		evict   = ((CW'(ctrl.count) + CW'(1)) > eff_cap) && (ctrl.count != '0);
		ev_rank = lru_kv_pkg::rank_t'(ctrl.count - lru_kv_pkg::count_t'(1));

		ctrl_next = ctrl;
		wr        = '0;
		wr.key    = key;
		wr.data   = val;
		valid_e   = ctrl.valid;
		count_e   = ctrl.count;
		free_oh   = '0;
		free_any  = 1'b0;

		if (hit) begin
			for (int i = 0; i < N; i++) begin
				if (match[i]) begin
					ctrl_next.rank[i] = '0;
				end else if (ctrl.valid[i] && (ctrl.rank[i] < hit_rank)) begin
					ctrl_next.rank[i] = lru_kv_pkg::rank_t'(ctrl.rank[i] + 1'b1);
				end
			end
			if (cmd == lru_kv_pkg::CMD_PUT) begin
				wr.sel = match;
			end
		end else if (cmd == lru_kv_pkg::CMD_PUT) begin
			if (evict) begin
				for (int i = 0; i < N; i++) begin
					if (ctrl.valid[i] && (ctrl.rank[i] == ev_rank)) begin
						valid_e[i]        = 1'b0;
						ctrl_next.rank[i] = '0;
					end
				end
				count_e = lru_kv_pkg::count_t'(ctrl.count - 1'b1);
			end
			for (int i = 0; i < N; i++) begin
				if (!valid_e[i] && !free_any) begin
					free_oh[i] = 1'b1;
					free_any   = 1'b1;
				end
			end
			ctrl_next.valid = valid_e;
			ctrl_next.count = count_e;
			if (free_any) begin
				for (int i = 0; i < N; i++) begin
					if (valid_e[i]) begin
						ctrl_next.rank[i] = lru_kv_pkg::rank_t'(ctrl.rank[i] + 1'b1);
					end else if (free_oh[i]) begin
						ctrl_next.rank[i] = '0;
					end
				end
				ctrl_next.valid = valid_e | free_oh;
				ctrl_next.count = lru_kv_pkg::count_t'(count_e + 1'b1);
				wr.sel          = free_oh;
				wr.key_en       = 1'b1;
			end
		end

		// head and tail taken from the state after this operation
		tail_rank          = lru_kv_pkg::rank_t'(ctrl_next.count - lru_kv_pkg::count_t'(1));
		result.head_value  = '0;
		result.tail_value  = '0;
		for (int i = 0; i < N; i++) begin
			dn = wr.sel[i] ? val : datas[i];
			if (ctrl_next.valid[i] && (ctrl_next.rank[i] == '0)) begin
				result.head_value = result.head_value | dn;
			end
			if (ctrl_next.valid[i] && (ctrl_next.rank[i] == tail_rank)) begin
				result.tail_value = result.tail_value | dn;
			end
		end

		result.found = hit;
		if (cmd == lru_kv_pkg::CMD_PUT) begin
			result.read_value = '0;
		end else if (hit) begin
			result.read_value = hit_data;
		end else begin
			result.read_value = lru_kv_pkg::READ_MISS;
		end
		result.store_empty = (ctrl_next.count == '0);
		result.occupancy   = ctrl_next.count;
	end

endmodule

@@ sv/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: input register, update pass, result register.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | command, key, value
//  cfg     | cfg_valid / cfg_ready| cfg_data (capacity)
//  out     | out_valid / out_ready| found, read_value, head_value, tail_value,
//          |                      | store_empty, occupancy
//
//  One item per cycle sustained while the output is not stalled; a result is offered
//  from the result register, which loads it from the input register through the
//  update pass; the single update pass sets that rate.
//  Reset clears valid bits, ranks and count, and sets capacity to 16; no clearing pass.
//  A stalled result holds the result register; the input register then holds too,
//  and in_ready drops only when both are full. cfg_ready is always high.
module lru_key_value_cache (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [0:0]               command,
	input  lru_kv_pkg::word_t        key,
	input  lru_kv_pkg::word_t        value,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  lru_kv_pkg::cap_t         cfg_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     found,
	output lru_kv_pkg::word_t        read_value,
	output lru_kv_pkg::word_t        head_value,
	output lru_kv_pkg::word_t        tail_value,
	output logic                     store_empty,
	output lru_kv_pkg::count_t       occupancy
);

	lru_kv_pkg::cap_t        capacity_q;

	logic                    valid_s1;
	lru_kv_pkg::cmd_t        cmd_s1;
	lru_kv_pkg::word_t       key_s1;
	lru_kv_pkg::word_t       val_s1;

	logic                    valid_s2;
	lru_kv_pkg::lru_result_t res_s2;

	logic                    advance;
	lru_kv_pkg::lru_ctrl_t   ctrl;
	lru_kv_pkg::lru_ctrl_t   ctrl_next;
	lru_kv_pkg::entry_wr_t   wr;
	lru_kv_pkg::lru_result_t result;
	lru_kv_pkg::word_t       keys [lru_kv_pkg::MAX_ENTRIES];
	lru_kv_pkg::word_t       datas [lru_kv_pkg::MAX_ENTRIES];

	// stage 1 moves into the result register when that is free or being drained;
	// the state commits on the same edge so the next item sees it
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lru_kv_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= lru_kv_pkg::cmd_t'(command);
			key_s1 <= key;
			val_s1 <= value;
		end
		if (advance) begin
			res_s2 <= result;
		end
	end

	lru_kv_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (advance),
		.ctrl_next (ctrl_next),
		.wr        (wr),
		.ctrl      (ctrl),
		.keys      (keys),
		.datas     (datas)
	);

	lru_kv_update u_update (
		.cmd       (cmd_s1),
		.key       (key_s1),
		.val       (val_s1),
		.capacity  (capacity_q),
		.ctrl      (ctrl),
		.keys      (keys),
		.datas     (datas),
		.ctrl_next (ctrl_next),
		.wr        (wr),
		.result    (result)
	);

	assign out_valid   = valid_s2;
	assign found       = res_s2.found;
	assign read_value  = res_s2.read_value;
	assign head_value  = res_s2.head_value;
	assign tail_value  = res_s2.tail_value;
	assign store_empty = res_s2.store_empty;
	assign occupancy   = res_s2.occupancy;

endmodule
